// ----- hdl/assert_macros.svh -----
// Assertion helpers included by the RTL back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/arpc_pkg.sv -----
`default_nettype none
package arpc_pkg;

   localparam int CACHE_ENTRIES_DEFAULT = 16;
   localparam int CMD_FIFO_DEPTH        = 4;
   localparam int OUT_FIFO_DEPTH        = 2;

   localparam logic [31:0] ALL_ONES_IP   = 32'hFFFF_FFFF;
   localparam logic [47:0] ALL_ONES_MAC  = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0] LIFETIME_RESET = 16'd150;
   localparam logic [7:0]  HW_LEN_ETH    = 8'd6;
   localparam logic [7:0]  PROTO_LEN_IP4 = 8'd4;

   // input operation codes
   localparam logic [1:0] OP_PACKET  = 2'd0;
   localparam logic [1:0] OP_RESOLVE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   // ARP opcodes
   localparam logic [15:0] ARP_REQUEST = 16'd1;
   localparam logic [15:0] ARP_REPLY   = 16'd2;

   // result kinds
   localparam logic [2:0] KIND_REPLY     = 3'd0;
   localparam logic [2:0] KIND_RESOLVED  = 3'd1;
   localparam logic [2:0] KIND_BROADCAST = 3'd2;
   localparam logic [2:0] KIND_REQUEST   = 3'd3;
   localparam logic [2:0] KIND_LINK_DOWN = 3'd4;

   // register indexes
   localparam logic [2:0] REG_OWN_IP   = 3'd0;
   localparam logic [2:0] REG_NET_MASK = 3'd1;
   localparam logic [2:0] REG_ROUTER   = 3'd2;
   localparam logic [2:0] REG_BCAST    = 3'd3;
   localparam logic [2:0] REG_LINK_UP  = 3'd4;
   localparam logic [2:0] REG_LIFETIME = 3'd5;

   typedef enum logic [1:0] {
      CMD_EMIT,
      CMD_STORE,
      CMD_LOOKUP,
      CMD_TICK
   } cmd_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } back_state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] arp_opcode;
      logic [7:0]  hw_addr_len;
      logic [7:0]  proto_addr_len;
      logic [47:0] src_mac;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [31:0] lookup_ip;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [47:0] mac_out;
      logic [31:0] ip_out;
   } rsp_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [2:0]  kind;
      logic [47:0] mac;
      logic [31:0] ip;
   } cmd_type;

   typedef struct packed {
      logic [31:0] own_ip;
      logic [31:0] net_mask;
      logic [31:0] router_ip;
      logic [31:0] bcast_ip;
      logic        link_up;
   } front_cfg_type;

endpackage
`default_nettype wire

// ----- hdl/arp_responder_and_cache_top.sv -----
// ARP responder and aging ARP cache for one interface.
// Input channel: a word is taken when push is high and full is low. Each word
// is a received ARP packet, a resolve query or a one-second tick.
// Result channel: while empty is low the oldest result sits on rsp_data; it
// is taken when pop is high. Results leave in the order of their words.
// Configuration: APB-style port, registers at byte address 4*index, pready
// always high; write only while the block is idle.
// Flow: a word is registered in the classifier, then waits in a short
// command queue. Replies, broadcast and link-down results, and ticks are
// handled by the back end straight from idle; a lookup or a cache store
// scans the memory one entry a cycle with registered read, a lookup
// ending early on a hit. The back end takes no new command during a scan.
// A stalled receiver fills the two-entry result queue, then the back end
// holds, the command queue fills and full rises.
// Reset clears the valid bits, the seconds counter and all queues; entry
// lifetime returns to 150 seconds, the other registers to zero.
`default_nettype none
module arp_responder_and_cache_top
   import arpc_pkg::*;
#(
   parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEFAULT
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire req_type     req_data,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   front_cfg_type cfg_ff;
   logic [15:0]   lifetime_ff;
   logic          csr_wr;
   logic [2:0]    csr_idx;
   logic          cmd_push, cmd_full, cmd_pop, cmd_avail;
   cmd_type       cmd_in_word, cmd_out_word;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel & penable & pwrite;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         lifetime_ff <= LIFETIME_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_OWN_IP:   cfg_ff.own_ip    <= pwdata;
            REG_NET_MASK: cfg_ff.net_mask  <= pwdata;
            REG_ROUTER:   cfg_ff.router_ip <= pwdata;
            REG_BCAST:    cfg_ff.bcast_ip  <= pwdata;
            REG_LINK_UP:  cfg_ff.link_up   <= pwdata[0];
            REG_LIFETIME: lifetime_ff      <= pwdata[15:0];
            default:      lifetime_ff      <= lifetime_ff;
         endcase
      end
   end

   // read back configuration
   always_comb begin
      unique case (csr_idx)
         REG_OWN_IP:   prdata = cfg_ff.own_ip;
         REG_NET_MASK: prdata = cfg_ff.net_mask;
         REG_ROUTER:   prdata = cfg_ff.router_ip;
         REG_BCAST:    prdata = cfg_ff.bcast_ip;
         REG_LINK_UP:  prdata = {31'd0, cfg_ff.link_up};
         REG_LIFETIME: prdata = {16'd0, lifetime_ff};
         default:      prdata = 32'd0;
      endcase
   end

   arpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_word (cmd_in_word)
   );

   arpc_cmd_fifo #(.DEPTH(CMD_FIFO_DEPTH)) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_word (cmd_in_word),
      .is_full (cmd_full),
      .rd_en   (cmd_pop),
      .rd_word (cmd_out_word),
      .avail   (cmd_avail)
   );

   arpc_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
      .clock          (clock),
      .reset          (reset),
      .entry_lifetime (lifetime_ff),
      .cmd_avail      (cmd_avail),
      .cmd_word       (cmd_out_word),
      .cmd_pop        (cmd_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_data       (rsp_data)
   );

endmodule
`default_nettype wire

// ----- hdl/arpc_front.sv -----
`default_nettype none
module arpc_front
   import arpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire front_cfg_type cfg,
   input  wire logic          push,
   output logic               full,
   input  wire req_type       req_data,
   output logic               cmd_push,
   input  wire logic          cmd_full,
   output cmd_type            cmd_word
);

   logic    vld_ff, vld_in;
   cmd_type cmd_ff, cmd_in;
   logic    has_cmd;
   logic    accept;
   logic [31:0] bcast_eff;
   logic        lip_bcast, rtr_bcast, off_net;

   assign full     = vld_ff & cmd_full;
   assign accept   = push & ~full;
   assign cmd_push = vld_ff & ~cmd_full;
   assign cmd_word = cmd_ff;

   // classify the incoming word into a back-end command
   always_comb begin
      bcast_eff = (cfg.bcast_ip != 32'd0) ? cfg.bcast_ip : ALL_ONES_IP;
      lip_bcast = (req_data.lookup_ip == bcast_eff) || (req_data.lookup_ip == ALL_ONES_IP);
      rtr_bcast = (cfg.router_ip == bcast_eff) || (cfg.router_ip == ALL_ONES_IP);
      off_net   = (cfg.own_ip != 32'd0) && (cfg.router_ip != 32'd0) &&
                  ((req_data.lookup_ip & cfg.net_mask) != (cfg.own_ip & cfg.net_mask));
      has_cmd   = 1'b0;
      cmd_in    = '{op: CMD_EMIT, kind: KIND_REPLY, mac: 48'd0, ip: 32'd0};
      case (req_data.operation)
         OP_PACKET: begin
            if (req_data.dst_ip == cfg.own_ip) begin
               if (req_data.arp_opcode == ARP_REQUEST) begin
                  if (req_data.hw_addr_len == HW_LEN_ETH &&
                      req_data.proto_addr_len == PROTO_LEN_IP4) begin
                     has_cmd = 1'b1;
                     cmd_in  = '{op: CMD_EMIT, kind: KIND_REPLY,
                                 mac: req_data.src_mac, ip: req_data.src_ip};
                  end
               end else if (req_data.arp_opcode == ARP_REPLY) begin
                  has_cmd = 1'b1;
                  cmd_in  = '{op: CMD_STORE, kind: KIND_REPLY,
                              mac: req_data.src_mac, ip: req_data.src_ip};
               end
            end
         end
         OP_RESOLVE: begin
            has_cmd = 1'b1;
            if (lip_bcast) begin
               cmd_in = '{op: CMD_EMIT, kind: KIND_BROADCAST, mac: ALL_ONES_MAC, ip: 32'd0};
            end else if (!cfg.link_up) begin
               cmd_in = '{op: CMD_EMIT, kind: KIND_LINK_DOWN, mac: 48'd0, ip: 32'd0};
            end else if (off_net && rtr_bcast) begin
               cmd_in = '{op: CMD_EMIT, kind: KIND_BROADCAST, mac: ALL_ONES_MAC, ip: 32'd0};
            end else begin
               cmd_in = '{op: CMD_LOOKUP, kind: KIND_REQUEST, mac: 48'd0,
                          ip: off_net ? cfg.router_ip : req_data.lookup_ip};
            end
         end
         OP_TICK: begin
            has_cmd = 1'b1;
            cmd_in  = '{op: CMD_TICK, kind: KIND_REPLY, mac: 48'd0, ip: 32'd0};
         end
         default: has_cmd = 1'b0;
      endcase
   end

   // hold the classified word until the queue takes it
   always_comb begin
      vld_in = vld_ff & cmd_full;
      if (accept && has_cmd) begin
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/arpc_cmd_fifo.sv -----
`default_nettype none
module arpc_cmd_fifo
   import arpc_pkg::*;
#(
   parameter int DEPTH = CMD_FIFO_DEPTH
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire cmd_type wr_word,
   output logic         is_full,
   input  wire logic    rd_en,
   output cmd_type      rd_word,
   output logic         avail
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_wr, do_rd;

   assign is_full = (cnt_ff == CNT_W'(DEPTH));
   assign avail   = (cnt_ff != '0);
   assign rd_word = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en & ~is_full;
   assign do_rd   = rd_en & avail;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/arpc_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module arpc_back
   import arpc_pkg::*;
#(
   parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEFAULT
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] entry_lifetime,
   input  wire logic        cmd_avail,
   input  wire cmd_type     cmd_word,
   output logic             cmd_pop,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data
);

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

   // cache storage
   logic [31:0] ip_mem    [CACHE_ENTRIES];
   logic [47:0] mac_mem   [CACHE_ENTRIES];
   logic [31:0] stamp_mem [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] valid_ff;

   back_state_type   state_ff, state_in;
   cmd_type          cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             issue_ff, issue_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [31:0]      rd_ip_ff, rd_stamp_ff;
   logic [47:0]      rd_mac_ff;
   logic [31:0]      now_ff, now_in;

   logic             mfound_ff, mfound_in, ffound_ff, ffound_in;
   logic [IDX_W-1:0] midx_ff, midx_in, fidx_ff, fidx_in, bidx_ff, bidx_in;
   logic [31:0]      bage_ff, bage_in;

   logic             wr_en, set_vld, clr_vld;
   logic [IDX_W-1:0] wr_addr;
   logic             cur_valid, cur_match, cur_last, expired;
   logic [31:0]      age;

   // result queue
   rsp_type          out_mem_ff [OUT_FIFO_DEPTH];
   logic             out_wp_ff, out_rp_ff;
   logic [1:0]       out_cnt_ff;
   logic             out_push, out_pop;
   rsp_type          out_word;

   assign empty    = (out_cnt_ff == 2'd0);
   assign rsp_data = out_mem_ff[out_rp_ff];
   assign out_pop  = pop & ~empty;

   // compare the entry read back against the current command
   always_comb begin
      cur_valid = valid_ff[rd_idx_ff];
      cur_match = cur_valid && (rd_ip_ff == cur_ff.ip);
      cur_last  = (rd_idx_ff == LAST_IDX);
      age       = now_ff - rd_stamp_ff;
      expired   = (age >= {16'd0, entry_lifetime});
   end

   // sequence commands: direct words, ticks and cache scans
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      issue_in  = issue_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      now_in    = now_ff;
      mfound_in = mfound_ff;
      ffound_in = ffound_ff;
      midx_in   = midx_ff;
      fidx_in   = fidx_ff;
      bidx_in   = bidx_ff;
      bage_in   = bage_ff;
      cmd_pop   = 1'b0;
      out_push  = 1'b0;
      out_word  = '{result_kind: cur_ff.kind, mac_out: 48'd0, ip_out: cur_ff.ip};
      wr_en     = 1'b0;
      set_vld   = 1'b0;
      clr_vld   = 1'b0;
      wr_addr   = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_avail && out_cnt_ff != 2'd2) begin
               cmd_pop = 1'b1;
               cur_in  = cmd_word;
               case (cmd_word.op)
                  CMD_EMIT: begin
                     out_push = 1'b1;
                     out_word = '{result_kind: cmd_word.kind, mac_out: cmd_word.mac,
                                  ip_out: cmd_word.ip};
                  end
                  CMD_TICK: now_in = now_ff + 32'd1;
                  default: begin
                     state_in  = ST_SCAN;
                     idx_in    = '0;
                     issue_in  = 1'b1;
                     mfound_in = 1'b0;
                     ffound_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue reads one entry a cycle
            if (issue_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff;
               if (idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (rd_vld_ff) begin
               if (cur_ff.op == CMD_LOOKUP) begin
                  if (cur_match) begin
                     out_push = 1'b1;
                     state_in = ST_IDLE;
                     issue_in = 1'b0;
                     if (expired) begin
                        clr_vld  = 1'b1;
                        out_word = '{result_kind: KIND_REQUEST, mac_out: 48'd0,
                                     ip_out: cur_ff.ip};
                     end else begin
                        out_word = '{result_kind: KIND_RESOLVED, mac_out: rd_mac_ff,
                                     ip_out: cur_ff.ip};
                     end
                  end else if (cur_last) begin
                     out_push = 1'b1;
                     state_in = ST_IDLE;
                     out_word = '{result_kind: KIND_REQUEST, mac_out: 48'd0,
                                  ip_out: cur_ff.ip};
                  end
               end else begin
                  // track same IP, first free and oldest entry
                  mfound_in = mfound_ff | cur_match;
                  midx_in   = mfound_ff ? midx_ff : rd_idx_ff;
                  ffound_in = ffound_ff | ~cur_valid;
                  fidx_in   = ffound_ff ? fidx_ff : rd_idx_ff;
                  if (rd_idx_ff == '0 || age > bage_ff) begin
                     bage_in = age;
                     bidx_in = rd_idx_ff;
                  end
                  if (cur_last) begin
                     wr_en    = 1'b1;
                     set_vld  = 1'b1;
                     state_in = ST_IDLE;
                     wr_addr  = mfound_in ? midx_in : (ffound_in ? fidx_in : bidx_in);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issue_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
         now_ff    <= 32'd0;
         valid_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= rd_vld_in;
         now_ff    <= now_in;
         if (set_vld) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (clr_vld) begin
            valid_ff[rd_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      rd_idx_ff <= rd_idx_in;
      mfound_ff <= mfound_in;
      ffound_ff <= ffound_in;
      midx_ff   <= midx_in;
      fidx_ff   <= fidx_in;
      bidx_ff   <= bidx_in;
      bage_ff   <= bage_in;
   end

   // cache memory: registered read, single write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ip_mem[wr_addr]    <= cur_ff.ip;
         mac_mem[wr_addr]   <= cur_ff.mac;
         stamp_mem[wr_addr] <= now_ff;
      end
      rd_ip_ff    <= ip_mem[idx_ff];
      rd_mac_ff   <= mac_mem[idx_ff];
      rd_stamp_ff <= stamp_mem[idx_ff];
   end

   // result queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_wp_ff  <= 1'b0;
         out_rp_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         if (out_push) begin
            out_wp_ff <= ~out_wp_ff;
         end
         if (out_pop) begin
            out_rp_ff <= ~out_rp_ff;
         end
         if (out_push && !out_pop) begin
            out_cnt_ff <= out_cnt_ff + 2'd1;
         end else if (out_pop && !out_push) begin
            out_cnt_ff <= out_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wp_ff] <= out_word;
      end
   end

   `ASSERT_CLK(a_out_cnt_bound, clock, reset, out_cnt_ff != 2'd3, "result queue overflow")
   `ASSERT_CLK(a_write_in_scan, clock, reset, !wr_en || state_ff == ST_SCAN, "write outside scan")
   `ASSERT_IMPL(a_tick_counts, clock, reset, state_ff == ST_IDLE && cmd_pop && cmd_word.op == CMD_TICK, now_ff == $past(now_ff) + 32'd1, "tick lost")
   `ASSERT_IMPL(a_scan_no_pop, clock, reset, state_ff == ST_SCAN, !cmd_pop || state_ff == ST_IDLE || $past(state_in) == ST_IDLE, "pop during scan")

endmodule
`default_nettype wire
